// ----- design/ddo_pkg.sv -----
// Shared types, constants and the quarter-wave sine table of the odometry block.
`timescale 1ns / 1ps
`default_nettype none
package ddo_pkg;

    localparam int ANGLE_INDEX_BITS = 10;
    localparam int ANGLE_W          = 32;
    localparam int POS_W            = 48;
    localparam int TOTAL_W          = 32;
    localparam int DELTA_W          = 4;
    localparam int DIST_W           = 24;
    localparam int SINE_MAG_W       = 17;
    localparam int SINE_W           = SINE_MAG_W + 1;
    localparam int SUM_W            = DELTA_W + 1;
    localparam int TRAVEL_W         = DIST_W + SUM_W + 1;
    localparam int FRAC_SHIFT       = 17;

    localparam int QTR_ADDR_W  = ANGLE_INDEX_BITS - 1;
    localparam int QTR_ENTRIES = (1 << (ANGLE_INDEX_BITS - 2)) + 1;

    localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 32;
    localparam logic [CFG_INDEX_W-1:0] REG_DIST_PER_STEP  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_THETA_PER_DIFF = 8'd1;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 2 * POS_W + ANGLE_W + 2 * TOTAL_W;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_LOOK = 5'b00010,
        ST_MUL  = 5'b00100,
        ST_ACC  = 5'b01000,
        ST_WAIT = 5'b10000
    } t_state;

    typedef struct packed {
        logic capture;     // latch the accepted deltas
        logic lookup;      // table read, travel product, heading and totals update
        logic multiply;    // travel times cosine and sine
        logic accumulate;  // add the shifted products to the position
        logic load_out;    // copy the pose into the output register
    } t_ctrl_cmd;

    typedef logic [SINE_MAG_W-1:0] t_qtr_tab [0:QTR_ENTRIES-1];

    // Magnitude of sin(pi/2 * h / quarter) in Q1.16, Taylor series through phi^13.
    function automatic logic [SINE_MAG_W-1:0] sine_mag(input int unsigned h);
        logic [63:0] phi;
        logic [63:0] phi2;
        logic [63:0] term;
        logic [63:0] sum;
        phi  = (64'(h) * PI_HALF_Q30) >> (ANGLE_INDEX_BITS - 2);
        phi2 = (phi * phi) >> 30;
        term = phi;
        sum  = phi;
        term = ((term * phi2) >> 30) / 64'd6;
        sum  = sum - term;
        term = ((term * phi2) >> 30) / 64'd20;
        sum  = sum + term;
        term = ((term * phi2) >> 30) / 64'd42;
        sum  = sum - term;
        term = ((term * phi2) >> 30) / 64'd72;
        sum  = sum + term;
        term = ((term * phi2) >> 30) / 64'd110;
        sum  = sum - term;
        term = ((term * phi2) >> 30) / 64'd156;
        sum  = sum + term;
        return SINE_MAG_W'((sum + 64'd8192) >> 14);
    endfunction

    function automatic t_qtr_tab build_qtr_tab();
        t_qtr_tab tab;
        for (int k = 0; k < QTR_ENTRIES; k++) begin
            tab[k] = sine_mag(k);
        end
        return tab;
    endfunction

    localparam t_qtr_tab SINE_QTR = build_qtr_tab();

endpackage
`default_nettype wire

// ----- design/ddo_ctrl.sv -----
// Sequencing state machine of the odometry block.
`timescale 1ns / 1ps
`default_nettype none
module ddo_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_ready,
    input  wire              i_out_ready,
    output logic             o_out_valid,
    output ddo_pkg::t_ctrl_cmd o_cmd
);
    import ddo_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_cmd.capture = (r_state == ST_IDLE) && i_in_valid;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_LOOK;
            end
            ST_LOOK: begin
                o_cmd.lookup = 1'b1;
                n_state      = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.multiply = 1'b1;
                n_state        = ST_ACC;
            end
            ST_ACC: begin
                o_cmd.accumulate = 1'b1;
                o_cmd.load_out   = out_free;
                n_state          = out_free ? ST_IDLE : ST_WAIT;
            end
            ST_WAIT: begin
                o_cmd.load_out = out_free;
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

    // An accepted item always starts with the table lookup.
    a_accept_to_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == ST_LOOK))
        else $error("accepted item did not enter lookup");

    // The accumulate step either hands over its result or parks it.
    a_acc_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ACC) |=> (r_state == ST_IDLE || r_state == ST_WAIT))
        else $error("accumulate step left to an unexpected state");

    // A waiting result is never overwritten.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> (!r_out_valid || i_out_ready))
        else $error("output register loaded over a pending result");

    // No new item is taken while the previous one is still parked.
    a_wait_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WAIT) |-> !o_in_ready)
        else $error("input accepted while a result is parked");

endmodule
`default_nettype wire

// ----- design/ddo_datapath.sv -----
// Pose datapath: configuration registers, sine lookup, multipliers and accumulators.
`timescale 1ns / 1ps
`default_nettype none
module ddo_datapath (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_cfg_write,
    input  wire [ddo_pkg::CFG_INDEX_W-1:0]        i_cfg_index,
    input  wire [ddo_pkg::CFG_DATA_W-1:0]         i_cfg_data,
    input  wire [ddo_pkg::IN_TDATA_W-1:0]         i_in_data,
    input  ddo_pkg::t_ctrl_cmd                    i_cmd,
    output logic [ddo_pkg::OUT_TDATA_W-1:0]       o_out_data
);
    import ddo_pkg::*;

    localparam logic [QTR_ADDR_W-1:0] QTR_IDX = QTR_ADDR_W'(1 << (ANGLE_INDEX_BITS - 2));

    logic        [DIST_W-1:0]  r_dist;
    logic signed [ANGLE_W-1:0] r_theta;

    logic signed [DELTA_W-1:0] r_dl, r_dr;
    logic signed [POS_W-1:0]   r_x, r_y;
    logic        [ANGLE_W-1:0] r_angle;
    logic        [TOTAL_W-1:0] r_lsum, r_rsum;

    logic signed [SINE_W-1:0]   r_sin, r_cos;
    logic signed [TRAVEL_W-1:0] r_p;
    logic signed [POS_W-1:0]    r_px, r_py;
    logic [OUT_TDATA_W-1:0]     r_out;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dist  <= '0;
            r_theta <= '0;
        end else if (i_cfg_write) begin
            if (i_cfg_index == REG_DIST_PER_STEP) r_dist <= i_cfg_data[DIST_W-1:0];
            if (i_cfg_index == REG_THETA_PER_DIFF) r_theta <= $signed(i_cfg_data);
        end
    end

    // Table addresses from the top bits of the old heading; cosine is a quarter turn on.
    logic [ANGLE_INDEX_BITS-1:0] sin_i, cos_i;
    logic [QTR_ADDR_W-1:0]       sin_h, cos_h;
    logic [SINE_MAG_W-1:0]       sin_mag, cos_mag;

    assign sin_i = r_angle[ANGLE_W-1 -: ANGLE_INDEX_BITS];
    assign cos_i = sin_i + ANGLE_INDEX_BITS'(QTR_IDX);

    always_comb begin
        sin_h = sin_i[QTR_ADDR_W-1:0];
        cos_h = cos_i[QTR_ADDR_W-1:0];
        if (sin_h > QTR_IDX) sin_h = ~sin_h + 1'b1;
        if (cos_h > QTR_IDX) cos_h = ~cos_h + 1'b1;
    end

    assign sin_mag = SINE_QTR[sin_h];
    assign cos_mag = SINE_QTR[cos_h];

    logic signed [SINE_W-1:0]   sin_s, cos_s;
    logic signed [SUM_W-1:0]    d_sum, d_diff;
    logic signed [TRAVEL_W-1:0] p_full;
    logic signed [ANGLE_W-1:0]  d_diff_ext, ang_step;

    assign sin_s = sin_i[ANGLE_INDEX_BITS-1] ? -$signed({1'b0, sin_mag})
                                             :  $signed({1'b0, sin_mag});
    assign cos_s = cos_i[ANGLE_INDEX_BITS-1] ? -$signed({1'b0, cos_mag})
                                             :  $signed({1'b0, cos_mag});

    assign d_sum      = SUM_W'(r_dl) + SUM_W'(r_dr);
    assign d_diff     = SUM_W'(r_dl) - SUM_W'(r_dr);
    assign p_full     = $signed({1'b0, r_dist}) * d_sum;
    assign d_diff_ext = ANGLE_W'(d_diff);
    assign ang_step   = r_theta * d_diff_ext;

    logic signed [POS_W-1:0] n_x, n_y;
    assign n_x = r_x + (r_px >>> FRAC_SHIFT);
    assign n_y = r_y + (r_py >>> FRAC_SHIFT);

    // Architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x     <= '0;
            r_y     <= '0;
            r_angle <= '0;
            r_lsum  <= '0;
            r_rsum  <= '0;
        end else begin
            if (i_cmd.lookup) begin
                r_angle <= r_angle + $unsigned(ang_step);
                r_lsum  <= r_lsum + $unsigned(TOTAL_W'(r_dl));
                r_rsum  <= r_rsum + $unsigned(TOTAL_W'(r_dr));
            end
            if (i_cmd.accumulate) begin
                r_x <= n_x;
                r_y <= n_y;
            end
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_dl <= $signed(i_in_data[DELTA_W-1:0]);
            r_dr <= $signed(i_in_data[2*DELTA_W-1:DELTA_W]);
        end
        if (i_cmd.lookup) begin
            r_sin <= sin_s;
            r_cos <= cos_s;
            r_p   <= p_full;
        end
        if (i_cmd.multiply) begin
            r_px <= POS_W'(r_p) * POS_W'(r_cos);
            r_py <= POS_W'(r_p) * POS_W'(r_sin);
        end
        if (i_cmd.load_out) begin
            if (i_cmd.accumulate) begin
                r_out <= {r_rsum, r_lsum, r_angle, n_y, n_x};
            end else begin
                r_out <= {r_rsum, r_lsum, r_angle, r_y, r_x};
            end
        end
    end

    assign o_out_data = r_out;

endmodule
`default_nettype wire

// ----- design/differential_drive_odometry_top.sv -----
// Top level of the differential-drive dead-reckoning odometry block.
//
//  Channel   Direction  Signals                          Carries
//  s_axis    in         tvalid, tready, tdata[7:0]       one tick of wheel deltas
//  m_axis    out        tvalid, tready, tdata[191:0]     the updated pose and totals
//  cfg       in         valid, ready, index[7:0], data   register writes
//
// An item accepted on s_axis goes through the lookup, multiply and accumulate states:
// table read, travel times cosine and sine, and accumulation; its result is then
// registered for m_axis. A new item is taken only in the idle state, once the previous
// one is through. Synchronous active-low reset clears the pose, the totals and both
// registers. When a result still waits in the output register, the next result is held
// inside the block and s_axis tready stays low until the output register frees up.
`timescale 1ns / 1ps
`default_nettype none
module differential_drive_odometry_top (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    // Input items, fields from bit 0 up: left_delta[3:0], right_delta[7:4]
    input  wire                                i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  wire [ddo_pkg::IN_TDATA_W-1:0]      i_s_axis_tdata,
    // Result items, fields from bit 0 up: pos_x[47:0], pos_y[95:48], heading[127:96],
    // left_total[159:128], right_total[191:160]
    output logic                               o_m_axis_tvalid,
    input  wire                                i_m_axis_tready,
    output logic [ddo_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    // Configuration writes: index 0 dist_per_step, index 1 theta_per_diff
    input  wire                                i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire [ddo_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  wire [ddo_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import ddo_pkg::*;

    t_ctrl_cmd cmd;

    // Registers can always be written; writes to unknown indexes are dropped.
    assign o_cfg_ready = 1'b1;

    // The controller paces each item through lookup, multiply and accumulate and owns
    // the output valid flag; the datapath holds all arithmetic and the pose state.
    ddo_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_out_ready(i_m_axis_tready),
        .o_out_valid(o_m_axis_tvalid),
        .o_cmd      (cmd)
    );

    ddo_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_write(i_cfg_valid & o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_in_data  (i_s_axis_tdata),
        .i_cmd      (cmd),
        .o_out_data (o_m_axis_tdata)
    );

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for the differential-drive odometry block.
`timescale 1ns / 1ps
`default_nettype none
module tb;

    import ddo_pkg::*;

    // Cycles with no handshake on any channel before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 2000;
    // Cycles left after the last result before registers are touched or the run ends.
    localparam int SETTLE_CYCLES = 8;
    // Indexes outside the register list; writes to them must change nothing.
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_INDEX = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_LAST_INDEX  = 8'hFF;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // Result fields, pos_x in the lowest bits.
    typedef struct packed {
        logic [TOTAL_W-1:0] right_total;
        logic [TOTAL_W-1:0] left_total;
        logic [ANGLE_W-1:0] heading;
        logic [POS_W-1:0]   pos_y;
        logic [POS_W-1:0]   pos_x;
    } t_pose;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic [IN_TDATA_W-1:0]   s_tdata = '0;
    logic                    m_tready = 1'b0;
    logic                    cfg_valid = 1'b0;
    logic [CFG_INDEX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;
    wire                     s_tready;
    wire                     m_tvalid;
    wire [OUT_TDATA_W-1:0]   m_tdata;
    wire                     cfg_ready;

    // Predicted block state and registers.
    logic [DIST_W-1:0]  dist_per_step_r = '0;
    logic [ANGLE_W-1:0] theta_per_diff_r = '0;
    logic [POS_W-1:0]   x_pos = '0;
    logic [POS_W-1:0]   y_pos = '0;
    logic [ANGLE_W-1:0] angle = '0;
    logic [TOTAL_W-1:0] left_tally = '0;
    logic [TOTAL_W-1:0] right_tally = '0;

    t_pose pose_q[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int errors = 0;
    int ticks_sent = 0;
    int poses_checked = 0;
    int reg_writes = 0;
    int idle_cycles = 0;

    differential_drive_odometry_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // The receiver stalls at random according to the current phase.
    always @(posedge i_clk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Signed Q1.16 sine for a full-circle table index, folded from a quarter wave
    // and evaluated by a Taylor series in Q30.
    function automatic longint sine_q16(input int unsigned k);
        int unsigned full_n;
        int unsigned half_n;
        int unsigned qtr_n;
        int unsigned i;
        int unsigned h;
        bit          neg;
        logic [63:0] phi;
        logic [63:0] phi2;
        logic [63:0] term;
        logic [63:0] acc;
        longint      r;
        full_n = 1 << ANGLE_INDEX_BITS;
        half_n = full_n >> 1;
        qtr_n  = full_n >> 2;
        i      = k & (full_n - 1);
        neg    = (i & half_n) != 0;
        h      = i & (half_n - 1);
        if (h > qtr_n) begin
            h = half_n - h;
        end
        phi  = (64'(h) * HALF_PI_Q30) >> (ANGLE_INDEX_BITS - 2);
        phi2 = (phi * phi) >> 30;
        term = phi;
        acc  = phi;
        for (int n = 1; n <= 6; n++) begin
            term = ((term * phi2) >> 30) / (64'(2 * n) * 64'(2 * n + 1));
            if (n % 2 == 1) begin
                acc = acc - term;
            end else begin
                acc = acc + term;
            end
        end
        r = longint'((acc + 64'd8192) >> 14);
        return neg ? -r : r;
    endfunction

    // Advances the predicted pose by one tick and queues the pose the block must report.
    task automatic advance_pose(input logic [IN_TDATA_W-1:0] d);
        logic signed [DELTA_W-1:0] dl;
        logic signed [DELTA_W-1:0] dr;
        longint      sdl;
        longint      sdr;
        longint      travel;
        longint      sn;
        longint      cs;
        longint      dx;
        longint      dy;
        longint      turn;
        int unsigned idx;
        t_pose       e;
        dl     = d[3:0];
        dr     = d[7:4];
        sdl    = dl;
        sdr    = dr;
        idx    = angle >> (ANGLE_W - ANGLE_INDEX_BITS);
        sn     = sine_q16(idx);
        cs     = sine_q16(idx + (1 << (ANGLE_INDEX_BITS - 2)));
        travel = longint'(dist_per_step_r) * (sdl + sdr);
        // The extra bit of the shift halves the summed travel; >>> floors.
        dx     = (travel * cs) >>> 17;
        dy     = (travel * sn) >>> 17;
        turn   = longint'($signed(theta_per_diff_r)) * (sdl - sdr);
        x_pos       = x_pos + dx[POS_W-1:0];
        y_pos       = y_pos + dy[POS_W-1:0];
        angle       = angle + turn[ANGLE_W-1:0];
        left_tally  = left_tally + sdl[TOTAL_W-1:0];
        right_tally = right_tally + sdr[TOTAL_W-1:0];
        e.pos_x       = x_pos;
        e.pos_y       = y_pos;
        e.heading     = angle;
        e.left_total  = left_tally;
        e.right_total = right_tally;
        pose_q.push_back(e);
    endtask

    // Offers one tick of deltas and returns at the clock edge that takes it. Valid is
    // left high so that a following tick can go out on the very next cycle.
    task automatic send_tick(input logic signed [3:0] left_d, input logic signed [3:0] right_d);
        logic [IN_TDATA_W-1:0] d;
        d = {right_d, left_d};
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        do @(negedge i_clk); while (s_tready !== 1'b1);
        advance_pose(d);
        ticks_sent++;
        @(posedge i_clk);
    endtask

    // Stops sending and waits until every queued pose has come back.
    task automatic drain_poses();
        s_tvalid <= 1'b0;
        while (pose_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(negedge i_clk); while (cfg_ready !== 1'b1);
        if (idx == REG_DIST_PER_STEP) begin
            dist_per_step_r = data[DIST_W-1:0];
        end else if (idx == REG_THETA_PER_DIFF) begin
            theta_per_diff_r = data;
        end
        reg_writes++;
        @(posedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_gains(input logic [CFG_DATA_W-1:0] step_len,
                             input logic [CFG_DATA_W-1:0] theta);
        drain_poses();
        write_reg(REG_DIST_PER_STEP, step_len);
        write_reg(REG_THETA_PER_DIFF, theta);
    endtask

    task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
            errors++;
        end
    endtask

    // Every result taken by the receiver is compared with the oldest prediction.
    // Inputs only move at rising edges, so the falling edge sees what the next rising
    // edge will take.
    always @(negedge i_clk) begin : pose_check
        t_pose got;
        t_pose want;
        if (i_rst_n && m_tvalid === 1'b1 && m_tready) begin
            got = m_tdata;
            if (pose_q.size() == 0) begin
                $display("%0t ns: pose with none expected, got %h", $time, got);
                errors++;
            end else begin
                want = pose_q.pop_front();
                check_field("pos_x", 64'(want.pos_x), 64'(got.pos_x));
                check_field("pos_y", 64'(want.pos_y), 64'(got.pos_y));
                check_field("heading", 64'(want.heading), 64'(got.heading));
                check_field("left_total", 64'(want.left_total), 64'(got.left_total));
                check_field("right_total", 64'(want.right_total), 64'(got.right_total));
            end
            poses_checked++;
        end
    end

    // Ends a hung run: counts cycles in which no channel completes a handshake.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if ((s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready) ||
                (cfg_valid && cfg_ready === 1'b1)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Run stalled for %0d cycles with %0d poses outstanding",
                         idle_cycles, pose_q.size());
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // Field extremes, every sign combination of the deltas and the register extremes.
    task automatic test_directed_extremes();
        set_gains(32'd65536, 32'h4000_0000);
        send_tick(4'sd0, 4'sd0);
        send_tick(4'sd7, 4'sd7);
        send_tick(-4'sd8, -4'sd8);
        send_tick(4'sd7, -4'sd8);
        send_tick(-4'sd8, 4'sd7);
        set_gains(32'h00FF_FFFF, 32'h7FFF_FFFF);
        send_tick(4'sd7, 4'sd7);
        send_tick(-4'sd8, -4'sd8);
        send_tick(4'sd7, -4'sd8);
        send_tick(-4'sd8, 4'sd7);
        set_gains(32'd0, 32'h8000_0000);
        send_tick(4'sd7, -4'sd8);
        send_tick(4'sd3, 4'sd4);
        set_gains(32'd1, 32'd0);
        send_tick(4'sd7, 4'sd7);
        send_tick(-4'sd8, -4'sd8);
    endtask

    // Writes to indexes beyond the list are ignored and wide values are cut to width.
    task automatic test_register_decode();
        drain_poses();
        write_reg(REG_SPARE_INDEX, $urandom);
        write_reg(REG_LAST_INDEX, $urandom);
        write_reg(REG_DIST_PER_STEP, 32'hFF00_0100);
        write_reg(REG_THETA_PER_DIFF, 32'hFFFF_FFFF);
        send_tick(4'sd5, -4'sd3);
        send_tick(-4'sd2, 4'sd6);
        send_tick(4'sd0, 4'sd0);
    endtask

    task automatic random_gains();
        logic [CFG_DATA_W-1:0] step_len;
        logic [CFG_DATA_W-1:0] theta;
        case ($urandom_range(3))
            0: step_len = 32'h00FF_FFFF;
            1: step_len = $urandom;
            default: step_len = $urandom_range(1 << 18);
        endcase
        case ($urandom_range(5))
            0: theta = 32'h8000_0000;
            1: theta = 32'h7FFF_FFFF;
            2: theta = $urandom_range(1 << 24);
            default: theta = $urandom;
        endcase
        set_gains(step_len, theta);
    endtask

    // One phase of random ticks under the given idling. Part-way through, the sender
    // holds off until every pose is back and the gains are changed.
    task automatic test_random_phase(input int n_ticks, input int send_idle, input int recv_stall);
        int drain_at;
        logic signed [3:0] left_d;
        logic signed [3:0] right_d;
        send_idle_pct  = send_idle;
        recv_stall_pct = recv_stall;
        random_gains();
        drain_at = $urandom_range(n_ticks / 4, 3 * n_ticks / 4);
        for (int k = 0; k < n_ticks; k++) begin
            if (k == drain_at) begin
                random_gains();
            end
            left_d  = ($urandom_range(7) == 0) ? ($urandom_range(1) ? 4'sd7 : -4'sd8)
                                               : 4'($urandom_range(15));
            right_d = ($urandom_range(7) == 0) ? ($urandom_range(1) ? 4'sd7 : -4'sd8)
                                               : 4'($urandom_range(15));
            send_tick(left_d, right_d);
        end
        drain_poses();
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_extremes();
        test_register_decode();
        test_random_phase(190, 0, 0);
        test_random_phase(190, 82, 0);
        test_random_phase(190, 0, 82);
        test_random_phase(180, 30, 30);
        drain_poses();
        $display("Sent %0d ticks and checked %0d poses across %0d register writes,",
                 ticks_sent, poses_checked, reg_writes);
        $display("under idle, sender-gap, receiver-stall and mixed phases; %0d mismatches.",
                 errors);
        if (errors == 0 && pose_q.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ----- filelist.f -----
design/ddo_pkg.sv
design/ddo_ctrl.sv
design/ddo_datapath.sv
design/differential_drive_odometry_top.sv
tb/tb.sv
